// ===== hdl/sshi_pkg.sv =====
`timescale 1ns / 1ps

package sshi_pkg;

    // Wrap bound for cross-connected strip lines, and cap on results per pair
    localparam int MaxWraps = 3;
    localparam int ResCap   = 16;
    localparam int IdxW     = 4;
    localparam int KW       = $clog2(ResCap);

    typedef logic signed [IdxW-1:0] widx_t;
    typedef logic [KW-1:0]          kcnt_t;

    typedef enum logic [2:0] {
        REG_TAN_FRONT     = 3'd0,
        REG_TAN_BACK      = 3'd1,
        REG_INV_TAN_DIFF  = 3'd2,
        REG_ACTIVE_WIDTH  = 3'd3,
        REG_ACTIVE_HEIGHT = 3'd4,
        REG_STRIP_PITCH   = 3'd5,
        REG_INV_WIDTH     = 3'd6,
        REG_PARALLEL      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [20:0] tan_front;
        logic signed [20:0] tan_back;
        logic signed [23:0] inv_tan_diff;
        logic [23:0]        active_width;
        logic [23:0]        active_height;
        logic [15:0]        strip_pitch;
        logic [31:0]        inv_active_width;
        logic               parallel_strips;
    } cfg_t;

    // One cluster pair after the per-item arithmetic
    typedef struct packed {
        logic               reject;
        logic signed [23:0] xf;
        logic signed [23:0] xb;
        widx_t              nf;
        widx_t              nb;
        logic [47:0]        var_x;
        logic [47:0]        var_y;
        logic signed [47:0] cov;
    } prep_t;

    // One front and back line pair
    typedef struct packed {
        logic               reject;
        logic               last;
        widx_t              i_f;
        widx_t              i_b;
        logic signed [23:0] xf;
        logic signed [23:0] xb;
        logic [47:0]        var_x;
        logic [47:0]        var_y;
        logic signed [47:0] cov;
    } pair_t;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607)
            r = 24'sd8388607;
        else if (v < -48'sd8388608)
            r = -24'sd8388608;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

// ===== hdl/sshi_in_if.sv =====
`timescale 1ns / 1ps

interface sshi_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] front_position;
    logic [15:0]        front_error;
    logic signed [23:0] back_position;
    logic [15:0]        back_error;

    modport source (output valid, front_position, front_error, back_position, back_error,
                    input ready);
    modport sink (input valid, front_position, front_error, back_position, back_error,
                  output ready);
endinterface

// ===== hdl/sshi_out_if.sv =====
`timescale 1ns / 1ps

interface sshi_out_if;
    logic               valid;
    logic               ready;
    logic               hit_found;
    logic               last_of_run;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic [47:0]        var_x;
    logic [47:0]        var_y;
    logic signed [47:0] cov_xy;
    logic signed [2:0]  front_wrap;
    logic signed [2:0]  back_wrap;

    modport source (output valid, hit_found, last_of_run, hit_x, hit_y, var_x, var_y, cov_xy,
                    front_wrap, back_wrap, input ready);
    modport sink (input valid, hit_found, last_of_run, hit_x, hit_y, var_x, var_y, cov_xy,
                  front_wrap, back_wrap, output ready);
endinterface

// ===== hdl/sshi_regs.sv =====
`timescale 1ns / 1ps

module sshi_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sshi_pkg::cfg_t     cfg
);

    sshi_pkg::cfg_t     cfg_reg;
    sshi_pkg::reg_idx_t idx;

    assign idx    = sshi_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                 <= '0;
            cfg_reg.parallel_strips <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                sshi_pkg::REG_TAN_FRONT:     cfg_reg.tan_front        <= pwdata[20:0];
                sshi_pkg::REG_TAN_BACK:      cfg_reg.tan_back         <= pwdata[20:0];
                sshi_pkg::REG_INV_TAN_DIFF:  cfg_reg.inv_tan_diff     <= pwdata[23:0];
                sshi_pkg::REG_ACTIVE_WIDTH:  cfg_reg.active_width     <= pwdata[23:0];
                sshi_pkg::REG_ACTIVE_HEIGHT: cfg_reg.active_height    <= pwdata[23:0];
                sshi_pkg::REG_STRIP_PITCH:   cfg_reg.strip_pitch      <= pwdata[15:0];
                sshi_pkg::REG_INV_WIDTH:     cfg_reg.inv_active_width <= pwdata;
                sshi_pkg::REG_PARALLEL:      cfg_reg.parallel_strips  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sshi_pkg::REG_TAN_FRONT:     prdata = {11'b0, cfg_reg.tan_front};
            sshi_pkg::REG_TAN_BACK:      prdata = {11'b0, cfg_reg.tan_back};
            sshi_pkg::REG_INV_TAN_DIFF:  prdata = {8'b0, cfg_reg.inv_tan_diff};
            sshi_pkg::REG_ACTIVE_WIDTH:  prdata = {8'b0, cfg_reg.active_width};
            sshi_pkg::REG_ACTIVE_HEIGHT: prdata = {8'b0, cfg_reg.active_height};
            sshi_pkg::REG_STRIP_PITCH:   prdata = {16'b0, cfg_reg.strip_pitch};
            sshi_pkg::REG_INV_WIDTH:     prdata = cfg_reg.inv_active_width;
            sshi_pkg::REG_PARALLEL:      prdata = {31'b0, cfg_reg.parallel_strips};
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== hdl/sshi_prep.sv =====
`timescale 1ns / 1ps

module sshi_prep (
    input  logic            clk,
    input  logic            rst_n,
    input  sshi_pkg::cfg_t  cfg,
    sshi_in_if.sink         cluster,
    output logic            out_valid,
    input  logic            out_ready,
    output sshi_pkg::prep_t out_item
);

    localparam int IdxW_L = sshi_pkg::IdxW;

    typedef struct packed {
        logic               reject;
        logic signed [23:0] xf;
        logic signed [23:0] xb;
    } carry_t;

    logic       en;
    logic [5:0] v_reg;

    // Config-derived terms, refreshed every cycle
    logic [23:0] gm, hm;
    logic [20:0] tfm, tbm;
    logic [46:0] fac_reg;
    logic [40:0] tf2_reg, tb2_reg;
    logic [44:0] htf_reg, htb_reg;

    carry_t car_reg [0:4];

    // stage 1
    logic [31:0] exf_reg, exb_reg;
    logic        rej1;
    // stage 2
    logic [31:0]        ef2_reg, eb2_reg;
    logic signed [30:0] tft_reg, tbt_reg;
    logic [63:0]        sqf, sqb;
    logic [64:0]        sqf_r, sqb_r;
    logic [45:0]        offf_r, offb_r;
    logic signed [30:0] offf, offb;
    // stage 3
    logic [63:0]        pfl_reg, pbl_reg;
    logic [40:0]        pfh_reg, pbh_reg;
    logic signed [53:0] scf_reg, scb_reg;
    logic [32:0]        s2_reg, s2_4_reg;
    sshi_pkg::widx_t    nf_reg, nb_reg, nf4_reg, nb4_reg, nf5_reg, nb5_reg;
    logic [29:0]        tfa, tba;
    logic [61:0]        wpf, wpb;
    logic [IdxW_L-1:0]  kf, kb;
    // stage 4
    logic [41:0]        sx_reg;
    logic [53:0]        scm_reg;
    logic               scn_reg, scn5_reg;
    logic [73:0]        pxf, pxb;
    logic signed [54:0] sc;
    // stage 5
    logic [63:0] a00_reg, b0_reg, c00_reg;
    logic [41:0] a01_reg;
    logic [46:0] a10_reg, b1_reg, c10_reg;
    logic [24:0] a11_reg;
    logic [53:0] c01_reg;
    logic [36:0] c11_reg;
    logic        s2h_reg;
    // stage 6
    logic [89:0]  vxp;
    logic [80:0]  vyp;
    logic [101:0] cvp;
    logic [46:0]  cm;
    sshi_pkg::prep_t res_reg;

    assign en            = !v_reg[5] || out_ready;
    assign cluster.ready = en;
    assign out_valid     = v_reg[5];
    assign out_item      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], cluster.valid};
    end

    always_comb
    begin
        gm  = cfg.inv_tan_diff[23] ? 24'(-cfg.inv_tan_diff) : 24'(cfg.inv_tan_diff);
        tfm = cfg.tan_front[20] ? 21'(-cfg.tan_front) : 21'(cfg.tan_front);
        tbm = cfg.tan_back[20] ? 21'(-cfg.tan_back) : 21'(cfg.tan_back);
        hm  = cfg.active_height;
    end

    always_ff @(posedge clk)
    begin
        fac_reg <= gm * gm;
        tf2_reg <= tfm * tfm;
        tb2_reg <= tbm * tbm;
        htf_reg <= hm * tfm;
        htb_reg <= hm * tbm;
    end

    // stage 1: error in cm, range check
    assign rej1 = cfg.parallel_strips || cluster.front_position[23] ||
                  (25'(cluster.front_position) > $signed({1'b0, cfg.active_width})) ||
                  cluster.back_position[23] ||
                  (25'(cluster.back_position) > $signed({1'b0, cfg.active_width}));

    // stage 2: squared errors, position shifted along the strip to the far edge
    always_comb
    begin
        sqf    = exf_reg * exf_reg;
        sqb    = exb_reg * exb_reg;
        sqf_r  = {1'b0, sqf} + (65'd1 << 31);
        sqb_r  = {1'b0, sqb} + (65'd1 << 31);
        offf_r = {1'b0, htf_reg} + (46'd1 << 15);
        offb_r = {1'b0, htb_reg} + (46'd1 << 15);
        offf   = $signed({2'b0, offf_r[44:16]});
        offb   = $signed({2'b0, offb_r[44:16]});
    end

    // stage 3: wrap counts
    always_comb
    begin
        tfa = tft_reg[30] ? 30'(-tft_reg) : 30'(tft_reg);
        tba = tbt_reg[30] ? 30'(-tbt_reg) : 30'(tbt_reg);
        wpf = tfa * cfg.inv_active_width;
        wpb = tba * cfg.inv_active_width;
        kf  = (wpf[61:40] > 22'(sshi_pkg::MaxWraps)) ? IdxW_L'(sshi_pkg::MaxWraps)
                                                     : wpf[40 +: IdxW_L];
        kb  = (wpb[61:40] > 22'(sshi_pkg::MaxWraps)) ? IdxW_L'(sshi_pkg::MaxWraps)
                                                     : wpb[40 +: IdxW_L];
    end

    // stage 4 sums
    always_comb
    begin
        pxf = {1'b0, pfh_reg, 32'b0} + {10'b0, pfl_reg} + (74'd1 << 31);
        pxb = {1'b0, pbh_reg, 32'b0} + {10'b0, pbl_reg} + (74'd1 << 31);
        sc  = 55'(scf_reg) + 55'(scb_reg);
    end

    // stage 6 sums
    always_comb
    begin
        vxp = 90'(a00_reg) + (90'(a01_reg) << 32) + (90'(a10_reg) << 32) +
              (90'(a11_reg) << 64) + (90'd1 << 31);
        vyp = 81'(b0_reg) + (81'(b1_reg) << 32) + (s2h_reg ? (81'(fac_reg) << 32) : 81'd0) +
              (81'd1 << 31);
        cvp = 102'(c00_reg) + (102'(c01_reg) << 32) + (102'(c10_reg) << 32) +
              (102'(c11_reg) << 64) + (102'd1 << 47);
        cm  = (cvp[101:48] > 54'h7FFF_FFFF_FFFF) ? 47'h7FFF_FFFF_FFFF : cvp[94:48];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            exf_reg       <= cluster.front_error * cfg.strip_pitch;
            exb_reg       <= cluster.back_error * cfg.strip_pitch;
            car_reg[0]    <= '{reject: rej1, xf: cluster.front_position,
                               xb: cluster.back_position};
            // stage 2
            ef2_reg       <= sqf_r[63:32];
            eb2_reg       <= sqb_r[63:32];
            tft_reg       <= cfg.tan_front[20] ? 31'(car_reg[0].xf) - offf
                                               : 31'(car_reg[0].xf) + offf;
            tbt_reg       <= cfg.tan_back[20] ? 31'(car_reg[0].xb) - offb
                                              : 31'(car_reg[0].xb) + offb;
            car_reg[1]    <= car_reg[0];
            // stage 3
            pfl_reg       <= ef2_reg * tb2_reg[31:0];
            pfh_reg       <= ef2_reg * tb2_reg[40:32];
            pbl_reg       <= eb2_reg * tf2_reg[31:0];
            pbh_reg       <= eb2_reg * tf2_reg[40:32];
            scf_reg       <= $signed({1'b0, ef2_reg}) * cfg.tan_back;
            scb_reg       <= $signed({1'b0, eb2_reg}) * cfg.tan_front;
            s2_reg        <= {1'b0, ef2_reg} + {1'b0, eb2_reg};
            nf_reg        <= tft_reg[30] ? -sshi_pkg::widx_t'(kf) : sshi_pkg::widx_t'(kf);
            nb_reg        <= tbt_reg[30] ? -sshi_pkg::widx_t'(kb) : sshi_pkg::widx_t'(kb);
            car_reg[2]    <= car_reg[1];
            // stage 4
            sx_reg        <= 42'(pxf[72:32]) + 42'(pxb[72:32]);
            scn_reg       <= sc[54];
            scm_reg       <= sc[54] ? 54'(-sc) : 54'(sc);
            s2_4_reg      <= s2_reg;
            nf4_reg       <= nf_reg;
            nb4_reg       <= nb_reg;
            car_reg[3]    <= car_reg[2];
            // stage 5: partial products against g squared
            a00_reg       <= fac_reg[31:0] * sx_reg[31:0];
            a01_reg       <= fac_reg[31:0] * sx_reg[41:32];
            a10_reg       <= fac_reg[46:32] * sx_reg[31:0];
            a11_reg       <= fac_reg[46:32] * sx_reg[41:32];
            b0_reg        <= fac_reg[31:0] * s2_4_reg[31:0];
            b1_reg        <= fac_reg[46:32] * s2_4_reg[31:0];
            s2h_reg       <= s2_4_reg[32];
            c00_reg       <= fac_reg[31:0] * scm_reg[31:0];
            c01_reg       <= fac_reg[31:0] * scm_reg[53:32];
            c10_reg       <= fac_reg[46:32] * scm_reg[31:0];
            c11_reg       <= fac_reg[46:32] * scm_reg[53:32];
            scn5_reg      <= scn_reg;
            nf5_reg       <= nf4_reg;
            nb5_reg       <= nb4_reg;
            car_reg[4]    <= car_reg[3];
            // stage 6: round and saturate
            res_reg.reject <= car_reg[4].reject;
            res_reg.xf     <= car_reg[4].xf;
            res_reg.xb     <= car_reg[4].xb;
            res_reg.nf     <= nf5_reg;
            res_reg.nb     <= nb5_reg;
            res_reg.var_x  <= (vxp[89:32] > 58'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF
                                                                : vxp[79:32];
            res_reg.var_y  <= (vyp[80:32] > 49'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF
                                                                : vyp[79:32];
            res_reg.cov    <= scn5_reg ? $signed({1'b0, cm}) : -$signed({1'b0, cm});
        end
    end

endmodule

// ===== hdl/sshi_seq.sv =====
`timescale 1ns / 1ps

module sshi_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sshi_pkg::prep_t in_item,
    output logic            pair_valid,
    input  logic            pair_ready,
    output sshi_pkg::pair_t pair
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    seq_state_t      state_reg;
    sshi_pkg::prep_t held_reg;
    sshi_pkg::widx_t fi_reg, bi_reg;
    sshi_pkg::widx_t f2, b1, b2;
    sshi_pkg::kcnt_t k_reg;
    logic            last;

    always_comb
    begin
        f2   = (held_reg.nf > 0) ? held_reg.nf : '0;
        b1   = (held_reg.nb < 0) ? held_reg.nb : '0;
        b2   = (held_reg.nb > 0) ? held_reg.nb : '0;
        last = held_reg.reject || (k_reg == sshi_pkg::kcnt_t'(sshi_pkg::ResCap - 1)) ||
               ((fi_reg == f2) && (bi_reg == b2));
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign pair_valid = (state_reg == ST_RUN);

    always_comb
    begin
        pair.reject = held_reg.reject;
        pair.last   = last;
        pair.i_f    = fi_reg;
        pair.i_b    = bi_reg;
        pair.xf     = held_reg.xf;
        pair.xb     = held_reg.xb;
        pair.var_x  = held_reg.var_x;
        pair.var_y  = held_reg.var_y;
        pair.cov    = held_reg.cov;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            held_reg <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fi_reg    <= '0;
            bi_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        fi_reg    <= (in_item.nf < 0) ? in_item.nf : '0;
                        bi_reg    <= (in_item.nb < 0) ? in_item.nb : '0;
                        k_reg     <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (pair_ready)
                    begin
                        if (last)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            // inner loop over back lines, outer over front lines
                            if (bi_reg == b2)
                            begin
                                bi_reg <= b1;
                                fi_reg <= fi_reg + sshi_pkg::widx_t'(1);
                            end
                            else
                                bi_reg <= bi_reg + sshi_pkg::widx_t'(1);
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/sshi_pair.sv =====
`timescale 1ns / 1ps

module sshi_pair (
    input  logic            clk,
    input  logic            rst_n,
    input  sshi_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  sshi_pkg::pair_t in_pair,
    sshi_out_if.source      hit
);

    typedef struct packed {
        logic               reject;
        logic               last;
        sshi_pkg::widx_t    i_f;
        sshi_pkg::widx_t    i_b;
        logic [47:0]        var_x;
        logic [47:0]        var_y;
        logic signed [47:0] cov;
    } carry_t;

    logic       en;
    logic [5:0] v_reg;
    carry_t     car_reg [0:4];
    logic [23:0] gm;
    logic        gneg;

    // Q1
    logic signed [28:0] iwf, iwb;
    logic signed [29:0] xfi_reg, xbi_reg;
    // Q2
    logic signed [50:0] nt1_reg, nt2_reg;
    logic signed [30:0] d_reg;
    // Q3
    logic signed [51:0] num;
    logic [51:0]        numm_reg;
    logic               numn_reg, numn4_reg;
    logic [30:0]        dm;
    logic [54:0]        dp_reg;
    logic               dn_reg;
    // Q4
    logic [55:0]        xl_reg;
    logic [43:0]        xh_reg;
    logic [55:0]        ymr;
    logic signed [40:0] ys;
    logic signed [40:0] y_reg;
    // Q5
    logic [76:0]        xp;
    logic signed [45:0] x_reg;
    logic               yin_reg;
    logic signed [23:0] hy_reg;
    // Q6
    logic               xin;
    logic signed [46:0] xc;
    logic signed [40:0] yc;

    assign gm   = cfg.inv_tan_diff[23] ? 24'(-cfg.inv_tan_diff) : 24'(cfg.inv_tan_diff);
    assign gneg = cfg.inv_tan_diff[23];

    assign en        = !v_reg[5] || hit.ready;
    assign in_ready  = en;
    assign hit.valid = v_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], in_valid};
    end

    always_comb
    begin
        iwf = in_pair.i_f * $signed({1'b0, cfg.active_width});
        iwb = in_pair.i_b * $signed({1'b0, cfg.active_width});
        num = 52'(nt1_reg) - 52'(nt2_reg);
        dm  = d_reg[30] ? 31'(-d_reg) : 31'(d_reg);
        ymr = {1'b0, dp_reg} + (56'd1 << 15);
        ys  = $signed({2'b0, ymr[54:16]});
        xp  = 77'(xl_reg) + (77'(xh_reg) << 32) + (77'd1 << 31);
        yc  = y_reg - $signed({18'b0, cfg.active_height[23:1]});
        xc  = 47'(x_reg) - $signed({24'b0, cfg.active_width[23:1]});
        xin = !x_reg[45] && (x_reg <= $signed({22'b0, cfg.active_width}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Q1: shift each line by its wrap count
            xfi_reg    <= 30'(in_pair.xf) - 30'(iwf);
            xbi_reg    <= 30'(in_pair.xb) - 30'(iwb);
            car_reg[0] <= '{reject: in_pair.reject, last: in_pair.last, i_f: in_pair.i_f,
                            i_b: in_pair.i_b, var_x: in_pair.var_x, var_y: in_pair.var_y,
                            cov: in_pair.cov};
            // Q2
            nt1_reg    <= cfg.tan_back * xfi_reg;
            nt2_reg    <= cfg.tan_front * xbi_reg;
            d_reg      <= 31'(xbi_reg) - 31'(xfi_reg);
            car_reg[1] <= car_reg[0];
            // Q3
            numn_reg   <= num[51];
            numm_reg   <= num[51] ? 52'(-num) : 52'(num);
            dp_reg     <= dm * gm;
            dn_reg     <= d_reg[30];
            car_reg[2] <= car_reg[1];
            // Q4
            xl_reg     <= numm_reg[31:0] * gm;
            xh_reg     <= numm_reg[51:32] * gm;
            numn4_reg  <= numn_reg;
            y_reg      <= (dn_reg ^ gneg) ? $signed({17'b0, cfg.active_height}) - ys
                                          : $signed({17'b0, cfg.active_height}) + ys;
            car_reg[3] <= car_reg[2];
            // Q5
            x_reg      <= (numn4_reg ^ gneg) ? -$signed({1'b0, xp[76:32]})
                                             : $signed({1'b0, xp[76:32]});
            yin_reg    <= !y_reg[40] && (y_reg <= $signed({17'b0, cfg.active_height}));
            hy_reg     <= sshi_pkg::sat24(48'(yc));
            car_reg[4] <= car_reg[3];
            // Q6: output register, zero every field but last_of_run on a rejected pair
            hit.last_of_run <= car_reg[4].last;
            if (car_reg[4].reject)
            begin
                hit.hit_found  <= 1'b0;
                hit.hit_x      <= '0;
                hit.hit_y      <= '0;
                hit.var_x      <= '0;
                hit.var_y      <= '0;
                hit.cov_xy     <= '0;
                hit.front_wrap <= '0;
                hit.back_wrap  <= '0;
            end
            else
            begin
                hit.hit_found  <= xin && yin_reg;
                hit.hit_x      <= sshi_pkg::sat24(48'(xc));
                hit.hit_y      <= hy_reg;
                hit.var_x      <= car_reg[4].var_x;
                hit.var_y      <= car_reg[4].var_y;
                hit.cov_xy     <= car_reg[4].cov;
                hit.front_wrap <= car_reg[4].i_f[2:0];
                hit.back_wrap  <= car_reg[4].i_b[2:0];
            end
        end
    end

endmodule

// ===== hdl/stereo_strip_hit_intersection.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Carries
// cluster   in   one front and one back cluster position with errors
// hit       out  one line-pair intersection: position, variances, wrap indices
// apb       in   configuration registers at byte address 4*index
//
// A cluster pair that gives n results (1 to 16) holds the line sequencer until its
// last pair is taken: one pair leaves per cycle while the line-pair stages accept,
// and it takes the next item only from idle. Reset clears valid bits, sequencer state
// and registers; data registers are not reset. A stall on hit freezes the line-pair
// stages and backs up through the sequencer into the per-item stages, so nothing is
// lost or repeated.
module stereo_strip_hit_intersection (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sshi_in_if.sink     cluster,
    sshi_out_if.source  hit
);

    sshi_pkg::cfg_t  cfg;
    sshi_pkg::prep_t prep_item;
    sshi_pkg::pair_t pair;
    logic            prep_valid, prep_ready;
    logic            pair_valid, pair_ready;

    // Configuration registers
    sshi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Per-item arithmetic: squared errors, variances, wrap counts, range check
    sshi_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cluster   (cluster),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_item  (prep_item)
    );

    // Walk the front and back wrap indices, one line pair per cycle while the line-pair stages accept
    sshi_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (prep_valid),
        .in_ready   (prep_ready),
        .in_item    (prep_item),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair)
    );

    // Intersect each line pair and register the result item
    sshi_pair u_pair (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (pair_valid),
        .in_ready (pair_ready),
        .in_pair  (pair),
        .hit      (hit)
    );

endmodule
